/* design/fst_pkg.sv */
package fst_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned EXP_W = 16;
  localparam int unsigned PER_W = 16;
  localparam int unsigned THR_W = 8;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd60;
  localparam logic [PER_W-1:0] PERIOD_RESET = 16'd10;
  localparam logic [THR_W-1:0] THRESH_RESET = 8'd200;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_MAINT = 1'b1;

  // One table entry as it sits in the session memory.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
    logic [TIME_W-1:0] last;
  } entry_t;

  // Status of the remainder unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

/* design/fst_rem.sv */
module fst_rem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fst_pkg::TIME_W-1:0] dividend,
  input  logic [fst_pkg::PER_W-1:0]  divisor,
  output fst_pkg::rem_status_t       status
);

  localparam int unsigned CW = $clog2(fst_pkg::TIME_W + 1);

  logic [fst_pkg::TIME_W-1:0] dvd;
  logic [fst_pkg::PER_W-1:0]  rem;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;
  logic [fst_pkg::PER_W:0]    trial;
  logic [fst_pkg::PER_W:0]    diff;
  logic                       take;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    trial = {rem, dvd[fst_pkg::TIME_W-1]};
    take  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(fst_pkg::TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[fst_pkg::TIME_W-2:0], 1'b0};
      rem <= take ? diff[fst_pkg::PER_W-1:0] : trial[fst_pkg::PER_W-1:0];
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

/* design/flow_session_table_top.sv */
// Flow session table. Sessions keyed by destination address, source port and
// destination port live in one synchronous memory of CAPACITY entries; packet
// requests, expiry sweeps and eviction scans walk that memory one entry per
// cycle through its single read port. After reset the block first clears the
// memory and holds req_stall high meanwhile; configuration writes are taken at
// any time. A packet request makes a full scan for a matching key and the
// lowest free slot, then one write. A maintenance request runs the bit-serial
// now modulo sweep_period check, the expiry sweep when it runs, and a
// full scan and drop for each entry evicted when occupancy exceeds
// eviction_threshold. One request is worked on at a time; the result sits in
// an output register, so the next request is taken while an earlier result
// still waits on result_stall.
module flow_session_table_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fst_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          kind,
  input  logic [fst_pkg::ADDR_W-1:0]    dest_addr,
  input  logic [fst_pkg::PORT_W-1:0]    src_port,
  input  logic [fst_pkg::PORT_W-1:0]    dst_port,
  input  logic [fst_pkg::TIME_W-1:0]    now,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          hit,
  output logic [fst_pkg::SLOT_W-1:0]    slot,
  output logic                          table_full,
  output logic [fst_pkg::CNT_OUT_W-1:0] removed_count,
  output logic [fst_pkg::CNT_OUT_W-1:0] occupancy
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > fst_pkg::CNT_OUT_W) ? CW : fst_pkg::CNT_OUT_W;
  localparam int unsigned SW = (AW > fst_pkg::SLOT_W) ? AW : fst_pkg::SLOT_W;
  localparam int unsigned EW = $bits(fst_pkg::entry_t);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_LOOK   = 10'b0000000100,
    ST_PWRITE = 10'b0000001000,
    ST_MOD    = 10'b0000010000,
    ST_SWEEP  = 10'b0000100000,
    ST_ECHECK = 10'b0001000000,
    ST_ESCAN  = 10'b0010000000,
    ST_EDROP  = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [fst_pkg::EXP_W-1:0] expiry_seconds;
  logic [fst_pkg::PER_W-1:0] sweep_period;
  logic [fst_pkg::THR_W-1:0] eviction_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_seconds     <= fst_pkg::EXPIRY_RESET;
      sweep_period       <= fst_pkg::PERIOD_RESET;
      eviction_threshold <= fst_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fst_pkg::REG_EXPIRY: expiry_seconds <= cfg_data;
        fst_pkg::REG_PERIOD: sweep_period <= cfg_data;
        fst_pkg::REG_THRESH: eviction_threshold <= cfg_data[fst_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The latched request.
  logic                       kind_q;
  logic [fst_pkg::ADDR_W-1:0] addr_q;
  logic [fst_pkg::PORT_W-1:0] sport_q;
  logic [fst_pkg::PORT_W-1:0] dport_q;
  logic [fst_pkg::TIME_W-1:0] now_q;

  logic accept;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= kind;
      addr_q  <= dest_addr;
      sport_q <= src_port;
      dport_q <= dst_port;
      now_q   <= now;
    end
  end

  // Session memory: one read port with registered data, one write port.
  logic [EW-1:0]       mem [CAPACITY];
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  fst_pkg::entry_t     mem_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  fst_pkg::entry_t     mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Scan bookkeeping: address issue counter and the returning-data tag.
  logic [AW:0]   scan_cnt;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic          scanning;
  logic          issue;
  logic          scan_end;

  assign scanning = (state == ST_LOOK) || (state == ST_SWEEP) || (state == ST_ESCAN);
  assign issue    = scanning && (scan_cnt < (AW+1)'(CAPACITY));
  assign scan_end = scanning && (scan_cnt == (AW+1)'(CAPACITY)) && !pend;
  assign mem_re   = issue;
  assign mem_raddr = scan_cnt[AW-1:0];

  // Per-request working state.
  logic [CW-1:0] count;
  logic [CW-1:0] removed;
  logic          found;
  logic [AW-1:0] match_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          best_any;
  logic [AW-1:0] best_idx;
  logic [fst_pkg::TIME_W-1:0] best_last;
  logic          evicting;
  logic          hit_r;
  logic          full_r;
  logic [AW-1:0] slot_r;

  logic key_match;
  logic expired;
  logic [fst_pkg::THR_W-1:0] keep;
  logic [XW-1:0] count_x;
  logic evict_more;

  assign key_match = mem_q.valid && (mem_q.addr == addr_q) &&
                     (mem_q.sport == sport_q) && (mem_q.dport == dport_q);
  // Expiry compares at one bit wider than the time so the sum cannot wrap.
  assign expired = mem_q.valid &&
                   (({1'b0, mem_q.last} + {{(fst_pkg::TIME_W - fst_pkg::EXP_W + 1){1'b0}},
                     expiry_seconds}) < {1'b0, now_q});
  assign keep    = eviction_threshold - (eviction_threshold >> 1);
  assign count_x = XW'(count);
  assign evict_more = evicting ? (count_x > XW'(keep)) : (count_x > XW'(eviction_threshold));

  // Remainder unit for the sweep-period check.
  fst_pkg::rem_status_t rem_st;
  logic rem_start;
  assign rem_start = accept && (kind == fst_pkg::KIND_MAINT) && (sweep_period != '0);

  fst_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (now),
    .divisor  (sweep_period),
    .status   (rem_st)
  );

  logic result_free;
  assign result_free = !result_valid || !result_stall;

  // Next state and the memory write port.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = scan_cnt[AW-1:0];
    mem_wdata  = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (scan_cnt == (AW+1)'(CAPACITY - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (kind == fst_pkg::KIND_PACKET) begin
            state_next = ST_LOOK;
          end else if (sweep_period != '0) begin
            state_next = ST_MOD;
          end else begin
            state_next = ST_ECHECK;
          end
        end
      end
      ST_LOOK: begin
        if (scan_end) begin
          state_next = ST_PWRITE;
        end
      end
      ST_PWRITE: begin
        mem_wdata.valid = 1'b1;
        mem_wdata.addr  = addr_q;
        mem_wdata.sport = sport_q;
        mem_wdata.dport = dport_q;
        mem_wdata.last  = now_q;
        mem_waddr       = found ? match_idx : free_idx;
        mem_we          = found || free_found;
        state_next      = ST_DONE;
      end
      ST_MOD: begin
        if (rem_st.done) begin
          state_next = rem_st.zero ? ST_SWEEP : ST_ECHECK;
        end
      end
      ST_SWEEP: begin
        mem_waddr = pend_idx;
        mem_wdata = mem_q;
        mem_wdata.valid = 1'b0;
        mem_we    = pend && expired;
        if (scan_end) begin
          state_next = ST_ECHECK;
        end
      end
      ST_ECHECK: begin
        state_next = evict_more ? ST_ESCAN : ST_DONE;
      end
      ST_ESCAN: begin
        if (scan_end) begin
          state_next = ST_EDROP;
        end
      end
      ST_EDROP: begin
        mem_waddr  = best_idx;
        mem_we     = 1'b1;
        state_next = ST_ECHECK;
      end
      ST_DONE: begin
        if (result_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      scan_cnt     <= '0;
      pend         <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
      evicting     <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == ST_DONE && result_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          scan_cnt <= (state_next == ST_CLEAR) ? scan_cnt + 1'b1 : '0;
        end
        ST_IDLE: begin
          scan_cnt <= '0;
          evicting <= 1'b0;
        end
        ST_LOOK, ST_SWEEP, ST_ESCAN: begin
          if (issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (state == ST_SWEEP && pend && expired) begin
            count <= count - 1'b1;
          end
        end
        ST_PWRITE: begin
          if (!found && free_found) begin
            count <= count + 1'b1;
          end
        end
        ST_ECHECK: begin
          scan_cnt <= '0;
          if (evict_more) begin
            evicting <= 1'b1;
          end
        end
        ST_EDROP: begin
          count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the request.
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx <= scan_cnt[AW-1:0];
    end
    case (state)
      ST_IDLE: begin
        found      <= 1'b0;
        free_found <= 1'b0;
        removed    <= '0;
        hit_r      <= 1'b0;
        full_r     <= 1'b0;
        slot_r     <= '0;
      end
      ST_LOOK: begin
        if (pend && key_match && !found) begin
          found     <= 1'b1;
          match_idx <= pend_idx;
        end
        if (pend && !mem_q.valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= pend_idx;
        end
      end
      ST_PWRITE: begin
        hit_r  <= found;
        full_r <= !found && !free_found;
        slot_r <= found ? match_idx : (free_found ? free_idx : '0);
      end
      ST_SWEEP: begin
        if (pend && expired) begin
          removed <= removed + 1'b1;
        end
      end
      ST_ECHECK: begin
        best_any <= 1'b0;
      end
      ST_ESCAN: begin
        // Strict compare in ascending slot order keeps the lowest slot on ties.
        if (pend && mem_q.valid && (!best_any || mem_q.last < best_last)) begin
          best_any  <= 1'b1;
          best_idx  <= pend_idx;
          best_last <= mem_q.last;
        end
      end
      ST_EDROP: begin
        removed <= removed + 1'b1;
      end
      default: ;
    endcase
  end

  // Result register, loaded only when the previous result has gone.
  logic [XW-1:0] removed_x;
  logic [SW-1:0] slot_x;
  assign removed_x = XW'(removed);
  assign slot_x    = SW'(slot_r);

  always_ff @(posedge clk) begin
    if (state == ST_DONE && result_free) begin
      hit           <= hit_r;
      table_full    <= full_r;
      slot          <= slot_x[fst_pkg::SLOT_W-1:0];
      removed_count <= removed_x[fst_pkg::CNT_OUT_W-1:0];
      occupancy     <= count_x[fst_pkg::CNT_OUT_W-1:0];
    end
  end

  // The occupancy count can never pass the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(CAPACITY))
    else $error("occupancy count above capacity");

  // An insert raises the occupancy by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PWRITE && !found && free_found) |=> (count == $past(count) + 1'b1))
    else $error("insert did not bump occupancy");

  // The remainder unit reports only while the sequencer waits on it.
  a_rem_owner: assert property (@(posedge clk) disable iff (rst)
    rem_st.done |-> (state == ST_MOD))
    else $error("remainder done outside of its wait state");

  // Read data returns only in a scanning state.
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> scanning)
    else $error("memory data returned outside a scan");

endmodule
